// File: hw/rtl/tim_pkg.sv
`timescale 1ns / 1ps

package tim_pkg;

  // digit store depth, default for the top level parameter
  localparam int DIGIT_CAPACITY = 32;

  // digit counters hold up to the largest store depth (64)
  localparam int CNT_W = 7;

  localparam logic [1:0] MODE_TEXT  = 2'd0;
  localparam logic [1:0] MODE_END   = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [1:0] DIFF_EQUAL   = 2'd0;
  localparam logic [1:0] DIFF_LESS    = 2'd1;
  localparam logic [1:0] DIFF_GREATER = 2'd2;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] text_byte;
    logic [4:0] digit_index;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic       result_negative;
    logic [5:0] result_length;
    logic [3:0] digit_value;
    logic       too_long;
  } out_item_t;

  // digit store write, bank selects one of the two ping-pong stores
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [CNT_W-1:0] addr;
    logic [3:0]       data;
  } dig_wr_t;

endpackage

// File: hw/rtl/tim_ram.sv
`timescale 1ns / 1ps

module tim_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/tim_core.sv
`timescale 1ns / 1ps

module tim_core #(
  parameter int DIGIT_CAPACITY = tim_pkg::DIGIT_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      proc,
  input  tim_pkg::in_item_t         item,
  input  tim_pkg::in_item_t         next_item,
  input  logic [3:0]                rdata_a,
  input  logic [3:0]                rdata_b,
  output tim_pkg::dig_wr_t          wr,
  output logic [tim_pkg::CNT_W-1:0] raddr,
  output tim_pkg::out_item_t        result
);

  localparam logic [tim_pkg::CNT_W-1:0] CAP = tim_pkg::CNT_W'(DIGIT_CAPACITY);

  logic [7:0]                prev_byte_r, prev_byte_nxt;
  logic                      open_r, open_nxt;
  logic                      neg_r, neg_nxt;
  logic [tim_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]                diff_r, diff_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [tim_pkg::CNT_W-1:0] best_cnt_r, best_cnt_nxt;
  logic                      best_neg_r, best_neg_nxt;
  logic                      have_best_r, have_best_nxt;
  logic                      ovf_seen_r, ovf_seen_nxt;
  logic                      best_bank_r, best_bank_nxt;

  logic                      is_dig, do_dig, do_close, start, smaller;
  logic [3:0]                dig, best_dig;
  logic [tim_pkg::CNT_W-1:0] base_cnt, idx_ext;
  logic [1:0]                base_diff;

  assign is_dig   = (item.mode == tim_pkg::MODE_TEXT) &&
                    (item.text_byte inside {[tim_pkg::CHAR_ZERO:tim_pkg::CHAR_NINE]});
  assign do_dig   = proc && is_dig;
  assign do_close = proc && open_r &&
                    (((item.mode == tim_pkg::MODE_TEXT) && !is_dig) ||
                     (item.mode == tim_pkg::MODE_END));
  assign start    = do_dig && !open_r;
  assign dig      = item.text_byte[3:0];
  assign best_dig = best_bank_r ? rdata_b : rdata_a;
  assign base_cnt = start ? '0 : cnt_r;
  assign base_diff = start ? tim_pkg::DIFF_EQUAL : diff_r;
  assign idx_ext  = tim_pkg::CNT_W'(item.digit_index);

  // sign, then length, then first differing digit
  always_comb begin
    if (best_neg_r != neg_r) begin
      smaller = neg_r;
    end else if (!neg_r) begin
      if (cnt_r != best_cnt_r) begin
        smaller = cnt_r < best_cnt_r;
      end else begin
        smaller = diff_r == tim_pkg::DIFF_LESS;
      end
    end else begin
      if (cnt_r != best_cnt_r) begin
        smaller = cnt_r > best_cnt_r;
      end else begin
        smaller = diff_r == tim_pkg::DIFF_GREATER;
      end
    end
  end

  always_comb begin
    prev_byte_nxt = prev_byte_r;
    open_nxt      = open_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    diff_nxt      = diff_r;
    ovf_nxt       = ovf_r;
    best_cnt_nxt  = best_cnt_r;
    best_neg_nxt  = best_neg_r;
    have_best_nxt = have_best_r;
    ovf_seen_nxt  = ovf_seen_r;
    best_bank_nxt = best_bank_r;
    wr.en         = 1'b0;
    wr.bank       = ~best_bank_r;
    wr.addr       = base_cnt;
    wr.data       = dig;

    if (proc) begin
      case (item.mode)
        tim_pkg::MODE_TEXT: begin
          prev_byte_nxt = item.text_byte;
        end
        tim_pkg::MODE_END: begin
          prev_byte_nxt = '0;
        end
        default: begin
        end
      endcase
    end

    if (do_dig) begin
      open_nxt = 1'b1;
      neg_nxt  = start ? (prev_byte_r == tim_pkg::CHAR_MINUS) : neg_r;
      diff_nxt = base_diff;
      ovf_nxt  = start ? 1'b0 : ovf_r;
      cnt_nxt  = base_cnt;
      if (base_cnt >= CAP) begin
        ovf_nxt = 1'b1;
      end else begin
        wr.en   = 1'b1;
        cnt_nxt = base_cnt + 1'b1;
        if ((base_diff == tim_pkg::DIFF_EQUAL) && have_best_r && (base_cnt < best_cnt_r)) begin
          if (dig < best_dig) begin
            diff_nxt = tim_pkg::DIFF_LESS;
          end else if (dig > best_dig) begin
            diff_nxt = tim_pkg::DIFF_GREATER;
          end
        end
      end
    end

    if (do_close) begin
      open_nxt = 1'b0;
      if (ovf_r) begin
        ovf_seen_nxt = 1'b1;
      end else if (!have_best_r || smaller) begin
        best_cnt_nxt  = cnt_r;
        best_neg_nxt  = neg_r;
        have_best_nxt = 1'b1;
        best_bank_nxt = ~best_bank_r;
      end
    end
  end

  // read address for the item entering behind this one
  always_comb begin
    if (next_item.mode == tim_pkg::MODE_QUERY) begin
      raddr = tim_pkg::CNT_W'(next_item.digit_index);
    end else if (open_nxt) begin
      raddr = cnt_nxt;
    end else begin
      raddr = '0;
    end
  end

  always_comb begin
    result.found           = have_best_nxt;
    result.result_negative = have_best_nxt & best_neg_nxt;
    result.result_length   = have_best_nxt ? best_cnt_nxt[5:0] : 6'd0;
    result.too_long        = ovf_seen_nxt;
    if ((item.mode == tim_pkg::MODE_QUERY) && have_best_r && (idx_ext < best_cnt_r)) begin
      result.digit_value = best_dig;
    end else begin
      result.digit_value = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_byte_r <= '0;
      open_r      <= 1'b0;
      neg_r       <= 1'b0;
      cnt_r       <= '0;
      diff_r      <= tim_pkg::DIFF_EQUAL;
      ovf_r       <= 1'b0;
      best_cnt_r  <= '0;
      best_neg_r  <= 1'b0;
      have_best_r <= 1'b0;
      ovf_seen_r  <= 1'b0;
      best_bank_r <= 1'b0;
    end else begin
      prev_byte_r <= prev_byte_nxt;
      open_r      <= open_nxt;
      neg_r       <= neg_nxt;
      cnt_r       <= cnt_nxt;
      diff_r      <= diff_nxt;
      ovf_r       <= ovf_nxt;
      best_cnt_r  <= best_cnt_nxt;
      best_neg_r  <= best_neg_nxt;
      have_best_r <= have_best_nxt;
      ovf_seen_r  <= ovf_seen_nxt;
      best_bank_r <= best_bank_nxt;
    end
  end

endmodule

// File: hw/rtl/text_integer_minimum_finder.sv
`timescale 1ns / 1ps
// channel | ports                          | payload
// input   | in_valid, in_ready, in_data    | tim_pkg::in_item_t (mode, byte, digit index)
// result  | out_valid, out_ready, out_data | tim_pkg::out_item_t (minimum summary, digit)
//
// one request per cycle while the result is not stalled; each request passes the input
// register (digit store read) and then the result register
// the two digit stores swap roles (current / minimum) when a new minimum is taken
// rst_n synchronous; store contents need no reset and are used only once written
// a stalled result holds the input register; in_ready follows out_ready combinationally

module text_integer_minimum_finder #(
  parameter int DIGIT_CAPACITY = tim_pkg::DIGIT_CAPACITY
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tim_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tim_pkg::out_item_t out_data
);

  localparam int ADDR_W = (DIGIT_CAPACITY > 1) ? $clog2(DIGIT_CAPACITY) : 1;

  logic               in_valid_r, in_valid_nxt;
  tim_pkg::in_item_t  in_r;
  logic               out_valid_r, out_valid_nxt;
  tim_pkg::out_item_t out_r;

  logic                      proc;      // request in the input register moves on
  logic                      in_fire;
  tim_pkg::dig_wr_t          wr;
  logic [tim_pkg::CNT_W-1:0] raddr;
  logic [3:0]                rdata_a, rdata_b;
  tim_pkg::out_item_t        result;

  assign proc          = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready      = !in_valid_r || proc;
  assign in_fire       = in_valid && in_ready;
  assign in_valid_nxt  = in_fire || (in_valid_r && !proc);
  assign out_valid_nxt = proc || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
    if (proc) begin
      out_r <= result;
    end
  end

  // state update, compare tracking and store addressing
  tim_core #(
    .DIGIT_CAPACITY(DIGIT_CAPACITY)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .proc     (proc),
    .item     (in_r),
    .next_item(in_data),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b),
    .wr       (wr),
    .raddr    (raddr),
    .result   (result)
  );

  // ping-pong digit stores, both read at the same address
  tim_ram #(
    .WIDTH(4),
    .DEPTH(DIGIT_CAPACITY)
  ) u_store_a (
    .clk  (clk),
    .we   (wr.en && !wr.bank),
    .waddr(wr.addr[ADDR_W-1:0]),
    .wdata(wr.data),
    .re   (in_fire),
    .raddr(raddr[ADDR_W-1:0]),
    .rdata(rdata_a)
  );

  tim_ram #(
    .WIDTH(4),
    .DEPTH(DIGIT_CAPACITY)
  ) u_store_b (
    .clk  (clk),
    .we   (wr.en && wr.bank),
    .waddr(wr.addr[ADDR_W-1:0]),
    .wdata(wr.data),
    .re   (in_fire),
    .raddr(raddr[ADDR_W-1:0]),
    .rdata(rdata_b)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hw/rtl/tim_checker.sv
`timescale 1ns / 1ps

module tim_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tim_pkg::out_item_t out_data
);

  logic seen_found_r, seen_long_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_found_r <= 1'b0;
      seen_long_r  <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_found_r <= seen_found_r | out_data.found;
      seen_long_r  <= seen_long_r | out_data.too_long;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input only backs up behind a waiting result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_found_r |-> out_data.found)
    else $error("found dropped");

  a_long_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_long_r |-> out_data.too_long)
    else $error("overflow flag dropped");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.result_length == 6'd0 &&
      !out_data.result_negative && out_data.digit_value == 4'd0)
    else $error("minimum fields set before any number");

endmodule

bind text_integer_minimum_finder tim_checker u_tim_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps

// keeps a running copy of the minimum search and the summaries it should produce
class minimum_tracker;
  // number being collected
  logic [7:0]                last_byte;
  bit                        in_number;
  bit                        num_negative;
  logic [tim_pkg::CNT_W-1:0] num_len;
  logic [3:0]                num_digits [tim_pkg::DIGIT_CAPACITY];
  logic [1:0]                num_order;
  bit                        num_too_long;
  // minimum so far
  logic [3:0]                min_digits [tim_pkg::DIGIT_CAPACITY];
  logic [tim_pkg::CNT_W-1:0] min_len;
  bit                        min_negative;
  bit                        min_valid;
  bit                        overflow_sticky;

  tim_pkg::out_item_t expected_summaries[$];
  int                 error_count;
  int                 result_count;

  function new();
    last_byte       = '0;
    in_number       = 1'b0;
    num_negative    = 1'b0;
    num_len         = '0;
    num_order       = tim_pkg::DIFF_EQUAL;
    num_too_long    = 1'b0;
    min_len         = '0;
    min_negative    = 1'b0;
    min_valid       = 1'b0;
    overflow_sticky = 1'b0;
    error_count     = 0;
    result_count    = 0;
    foreach (num_digits[i]) begin
      num_digits[i] = '0;
      min_digits[i] = '0;
    end
  endfunction

  function void append_digit(logic [3:0] d);
    if (num_len >= tim_pkg::DIGIT_CAPACITY) begin
      num_too_long = 1'b1;
      return;
    end
    num_digits[num_len] = d;
    // first differing digit against the minimum, most significant first
    if (num_order == tim_pkg::DIFF_EQUAL && min_valid && num_len < min_len) begin
      if (d < min_digits[num_len]) num_order = tim_pkg::DIFF_LESS;
      else if (d > min_digits[num_len]) num_order = tim_pkg::DIFF_GREATER;
    end
    num_len++;
  endfunction

  function bit beats_minimum();
    if (min_negative && !num_negative) return 1'b0;
    if (!min_negative && num_negative) return 1'b1;
    if (!num_negative) begin
      if (num_len < min_len) return 1'b1;
      if (num_len > min_len) return 1'b0;
      return num_order == tim_pkg::DIFF_LESS;
    end
    if (num_len > min_len) return 1'b1;
    if (num_len < min_len) return 1'b0;
    return num_order == tim_pkg::DIFF_GREATER;
  endfunction

  function void finish_number();
    if (!in_number) return;
    in_number = 1'b0;
    if (num_too_long) begin
      overflow_sticky = 1'b1;
      return;
    end
    if (!min_valid || beats_minimum()) begin
      for (int i = 0; i < num_len; i++) min_digits[i] = num_digits[i];
      min_len      = num_len;
      min_negative = num_negative;
      min_valid    = 1'b1;
    end
  endfunction

  function void note_request(tim_pkg::in_item_t req);
    tim_pkg::out_item_t summary;
    logic [3:0]         digit_out;
    digit_out = '0;
    case (req.mode)
      tim_pkg::MODE_TEXT: begin
        if (req.text_byte >= tim_pkg::CHAR_ZERO && req.text_byte <= tim_pkg::CHAR_NINE) begin
          if (!in_number) begin
            in_number    = 1'b1;
            num_negative = (last_byte == tim_pkg::CHAR_MINUS);
            num_len      = '0;
            num_order    = tim_pkg::DIFF_EQUAL;
            num_too_long = 1'b0;
          end
          append_digit(4'(req.text_byte - tim_pkg::CHAR_ZERO));
        end else begin
          finish_number();
        end
        last_byte = req.text_byte;
      end
      tim_pkg::MODE_END: begin
        finish_number();
        last_byte = '0;
      end
      tim_pkg::MODE_QUERY: begin
        if (min_valid && req.digit_index < min_len) digit_out = min_digits[req.digit_index];
      end
      default: ;
    endcase
    summary.found           = min_valid;
    summary.result_negative = min_valid && min_negative;
    summary.result_length   = min_valid ? min_len[5:0] : 6'd0;
    summary.digit_value     = digit_out;
    summary.too_long        = overflow_sticky;
    expected_summaries.push_back(summary);
  endfunction

  task report_mismatch(string what);
    error_count++;
    $display("ERROR: %s", what);
  endtask

  task check_summary(tim_pkg::out_item_t got);
    tim_pkg::out_item_t want;
    if (expected_summaries.size() == 0) begin
      report_mismatch($sformatf("result with no request pending: %p", got));
      return;
    end
    want = expected_summaries.pop_front();
    if (got.found !== want.found)
      report_mismatch($sformatf("result %0d found %b, expected %b",
                                result_count, got.found, want.found));
    if (got.result_negative !== want.result_negative)
      report_mismatch($sformatf("result %0d negative %b, expected %b",
                                result_count, got.result_negative, want.result_negative));
    if (got.result_length !== want.result_length)
      report_mismatch($sformatf("result %0d length %0d, expected %0d",
                                result_count, got.result_length, want.result_length));
    if (got.digit_value !== want.digit_value)
      report_mismatch($sformatf("result %0d digit %0d, expected %0d",
                                result_count, got.digit_value, want.digit_value));
    if (got.too_long !== want.too_long)
      report_mismatch($sformatf("result %0d too_long %b, expected %b",
                                result_count, got.too_long, want.too_long));
    result_count++;
  endtask
endclass

module tb_top;

  localparam logic [1:0] MODE_UNUSED = 2'd3;  // no state change, digit reads as zero
  localparam logic [7:0] CHAR_SPACE  = 8'h20;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  tim_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  tim_pkg::out_item_t out_data;

  minimum_tracker tracker = new();

  // idling knobs, changed between phases by the main sequence
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // long receiver hold-off, asked by the main sequence, counted by the receiver
  bit hold_request   = 1'b0;
  bit hold_done      = 1'b0;
  int hold_left      = 0;
  int items_sent     = 0;

  text_integer_minimum_finder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off so the pipeline backs up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 60;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // every accepted result goes against the oldest expected summary
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_summary(out_data);
  end

  // one request; sender may idle first, valid then holds until accepted
  task automatic send_item(input tim_pkg::in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_request(req);
    items_sent++;
  endtask

  // text byte; the unused index field gets random content
  task automatic send_byte(input logic [7:0] b);
    tim_pkg::in_item_t req;
    req.mode        = tim_pkg::MODE_TEXT;
    req.text_byte   = b;
    req.digit_index = 5'($urandom_range(31));
    send_item(req);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_end();
    tim_pkg::in_item_t req;
    req.mode        = tim_pkg::MODE_END;
    req.text_byte   = 8'($urandom_range(255));
    req.digit_index = 5'($urandom_range(31));
    send_item(req);
  endtask

  task automatic send_query(input logic [1:0] mode, input logic [4:0] idx);
    tim_pkg::in_item_t req;
    req.mode        = mode;
    req.text_byte   = 8'($urandom_range(255));
    req.digit_index = idx;
    send_item(req);
  endtask

  // any non-digit byte, with plain spaces favored
  function automatic logic [7:0] random_separator();
    logic [7:0] b;
    if ($urandom_range(1) == 1) return CHAR_SPACE;
    do b = 8'($urandom_range(255)); while (b >= tim_pkg::CHAR_ZERO && b <= tim_pkg::CHAR_NINE);
    return b;
  endfunction

  // mostly well-formed numbers with random sign, length and digits,
  // mixed with end of text, queries and raw noise bytes
  task automatic run_random(input int n_items, input int neg_pct, input bit long_neg_ok);
    int         stop_at;
    int         pick;
    int         len;
    bit         neg;
    bit         narrow;
    logic [4:0] idx;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        neg = ($urandom_range(99) < neg_pct);
        send_byte(neg ? tim_pkg::CHAR_MINUS : random_separator());
        pick = $urandom_range(99);
        if (pick < 60) len = $urandom_range(1, 3);
        else if (pick < 95) len = $urandom_range(4, 8);
        else if (neg && !long_neg_ok) len = $urandom_range(1, 3);
        // long ones straddle the store size: exactly full, one over, or around it
        else if ($urandom_range(1) == 1) len = $urandom_range(32, 33);
        else len = $urandom_range(28, 40);
        // a narrow digit set makes equal prefixes common
        narrow = $urandom_range(1);
        repeat (len)
          send_byte(8'(tim_pkg::CHAR_ZERO + (narrow ? $urandom_range(1) : $urandom_range(9))));
      end else if (pick < 80) begin
        send_end();
      end else if (pick < 95) begin
        if (tracker.min_len != 0 && $urandom_range(1) == 1)
          idx = 5'($urandom_range(tracker.min_len - 1));
        else
          idx = 5'($urandom_range(31));
        send_query(tim_pkg::MODE_QUERY, idx);
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, no idling
    send_query(tim_pkg::MODE_QUERY, 5'd0);   // nothing found yet
    send_query(MODE_UNUSED, 5'd0);           // unused mode
    send_byte(8'h00);
    send_text("-7");
    send_byte(8'hFF);                        // closes -7, first minimum
    send_query(tim_pkg::MODE_QUERY, 5'd0);
    send_query(tim_pkg::MODE_QUERY, 5'd31);  // index past the length
    send_text("-");
    send_end();                              // end of text drops the pending minus sign
    send_text("5-");                         // positive 5 does not beat -7
    send_end();
    send_text("007");                        // leading zeros count as digits
    send_end();
    send_text("-09");
    send_byte(8'h00);                        // two digits beat one when negative
    send_text("-10");
    send_end();                              // first differing digit decides
    send_query(tim_pkg::MODE_QUERY, 5'd1);
    send_query(MODE_UNUSED, 5'd1);

    // random part, one phase per idling setting
    hold_request = 1'b1;                // long hold-off while the sender keeps going
    run_random(180, 5, 1'b0);

    send_idle_pct  = 83;
    recv_stall_pct = 0;
    run_random(180, 10, 1'b0);

    send_idle_pct  = 0;
    recv_stall_pct = 83;
    run_random(180, 15, 1'b0);

    send_idle_pct  = 38;
    recv_stall_pct = 38;
    run_random(180, 25, 1'b1);

    in_valid <= 1'b0;
    // drain: every expected summary must arrive, then idle clocks catch any strays
    while (tracker.expected_summaries.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (tracker.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
